### rtl/core/isotp_rx_pkg.sv
// Shared types and constants for the ISO-TP receive reassembler.
// Used by the decoder, the sequencer and the top level; depends on nothing.

package isotp_rx_pkg;

    // Widths of the packed stream words.
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 88;

    // Protocol control information, high nibble of data byte 0.
    localparam logic [3:0] PCI_SINGLE = 4'h0;
    localparam logic [3:0] PCI_FIRST  = 4'h1;
    localparam logic [3:0] PCI_CONSEC = 4'h2;

    // Flow control frame: continue to send, block size 0, separation time 0.
    localparam logic [7:0] FC_CTS_BYTE = 8'h30;

    // Bytes carried by each frame type.
    localparam logic [3:0] SF_MAX_BYTES = 4'd7;
    localparam logic [2:0] FF_BYTES     = 3'd6;
    localparam logic [2:0] CF_MAX_BYTES = 3'd7;

    // Result kinds.
    localparam logic KIND_FLOW  = 1'b0;
    localparam logic KIND_CHUNK = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_ENABLE      = 2'd0;
    localparam logic [1:0] REG_REQUEST_ID  = 2'd1;
    localparam logic [1:0] REG_RESPONSE_ID = 2'd2;

    localparam logic [10:0] REQUEST_ID_RESET  = 11'd2016;
    localparam logic [10:0] RESPONSE_ID_RESET = 11'd2024;

    typedef enum logic [1:0] {
        FT_NONE,
        FT_SINGLE,
        FT_FIRST,
        FT_CONSEC
    } frame_type_t;

    typedef struct packed {
        frame_type_t ftype;
        logic [3:0]  nib;
        logic [3:0]  sf_len;
        logic [8:0]  ff_len;
        logic [63:0] sf_word;
        logic [63:0] frame_data;
    } frame_info_t;

    typedef struct packed {
        logic        enable;
        logic [10:0] request_id;
        logic [10:0] response_id;
    } cfg_t;

endpackage

### rtl/core/isotp_rx_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Self-contained; no package needed.

module isotp_rx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/isotp_rx_decode.sv
// Frame filter and classifier: checks identifier, length and enable, and
// decodes the protocol control byte. Depends on isotp_rx_pkg.

module isotp_rx_decode #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic [10:0]               can_id,
    input  logic [3:0]                frame_length,
    input  logic [63:0]               frame_data,
    input  isotp_rx_pkg::cfg_t        cfg,
    output isotp_rx_pkg::frame_info_t info
);

    localparam int LENGTH_CAP = (BUFFER_BYTES < 256) ? BUFFER_BYTES : 256;

    logic [3:0]  pci;
    logic [3:0]  nib;
    logic [3:0]  sf_len;
    logic [11:0] ff_raw;
    logic [63:0] shifted;
    logic [63:0] sf_word;
    logic        match;

    assign pci     = frame_data[63:60];
    assign nib     = frame_data[59:56];
    assign sf_len  = (nib > isotp_rx_pkg::SF_MAX_BYTES) ? isotp_rx_pkg::SF_MAX_BYTES : nib;
    assign ff_raw  = {nib, frame_data[55:48]};
    assign shifted = {frame_data[55:0], 8'h00};
    assign match   = cfg.enable && (can_id == cfg.request_id) && (frame_length != 4'd0);

    // Keep only the bytes the single frame actually carries.
    always_comb
    begin
        sf_word = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < sf_len)
            begin
                sf_word[8*(7-i) +: 8] = shifted[8*(7-i) +: 8];
            end
        end
    end

    always_comb
    begin
        info.nib        = nib;
        info.sf_len     = sf_len;
        info.ff_len     = (32'(ff_raw) > LENGTH_CAP) ? 9'(LENGTH_CAP) : ff_raw[8:0];
        info.sf_word    = sf_word;
        info.frame_data = frame_data;
        info.ftype      = isotp_rx_pkg::FT_NONE;
        if (match)
        begin
            case (pci)
                isotp_rx_pkg::PCI_SINGLE:
                begin
                    if (sf_len != 4'd0)
                    begin
                        info.ftype = isotp_rx_pkg::FT_SINGLE;
                    end
                end
                isotp_rx_pkg::PCI_FIRST:  info.ftype = isotp_rx_pkg::FT_FIRST;
                isotp_rx_pkg::PCI_CONSEC: info.ftype = isotp_rx_pkg::FT_CONSEC;
                default:                  info.ftype = isotp_rx_pkg::FT_NONE;
            endcase
        end
    end

endmodule

### rtl/core/isotp_rx_seq.sv
// Reassembly sequencer: writes frame bytes into the message RAM one per cycle,
// reads a completed message back in chunks of up to 8 bytes and drives the output register.
// Depends on isotp_rx_pkg; the RAM sits beside it in the top level.

module isotp_rx_reasm #(
    parameter int BUFFER_BYTES = 256,
    localparam int AW = $clog2(BUFFER_BYTES)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  isotp_rx_pkg::frame_info_t info,
    input  logic [10:0]               response_id,
    output logic                      wr_en,
    output logic [AW-1:0]             wr_addr,
    output logic [7:0]                wr_data,
    output logic [AW-1:0]             rd_addr,
    input  logic [7:0]                rd_data,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [isotp_rx_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                      m_axis_tuser,
    output logic                      m_axis_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_CHUNK_START,
        ST_READ,
        ST_PUSH
    } state_t;

    state_t      state_reg, state_next;

    // Reception state.
    logic [8:0]  len_reg, len_next;
    logic [8:0]  wp_reg, wp_next;
    logic [3:0]  seq_reg, seq_next;
    logic        recv_reg, recv_next;

    // Byte writer.
    logic [63:0] data_reg, data_next;
    logic [8:0]  wr_pos_reg, wr_pos_next;
    logic [2:0]  src_reg, src_next;
    logic [2:0]  left_reg, left_next;
    logic        after_push_reg, after_push_next;
    logic        emit_reg, emit_next;

    // Chunk reader.
    logic [8:0]  rd_pos_reg, rd_pos_next;
    logic [3:0]  idx_reg, idx_next;
    logic        rd_pend_reg, rd_pend_next;
    logic [2:0]  slot_reg, slot_next;

    // Pending result.
    logic        pend_kind_reg, pend_kind_next;
    logic [10:0] pend_id_reg, pend_id_next;
    logic [63:0] pend_data_reg, pend_data_next;
    logic [3:0]  pend_bytes_reg, pend_bytes_next;
    logic [8:0]  pend_mlen_reg, pend_mlen_next;
    logic        pend_multi_reg, pend_multi_next;

    // Output register.
    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [10:0] out_id_reg, out_id_next;
    logic [63:0] out_data_reg, out_data_next;
    logic [3:0]  out_bytes_reg, out_bytes_next;
    logic [8:0]  out_mlen_reg, out_mlen_next;
    logic        out_last_reg, out_last_next;

    logic        out_free;
    logic [8:0]  cf_rem;
    logic [2:0]  cf_n;
    logic [8:0]  cf_wp_end;
    logic [8:0]  chunk_rem;
    logic        chunk_last;

    assign out_free   = !out_valid_reg || m_axis_tready;
    assign cf_rem     = (wp_reg < len_reg) ? (len_reg - wp_reg) : 9'd0;
    assign cf_n       = (cf_rem > 9'(isotp_rx_pkg::CF_MAX_BYTES)) ?
                        isotp_rx_pkg::CF_MAX_BYTES : cf_rem[2:0];
    assign cf_wp_end  = wp_reg + 9'(cf_n);
    assign chunk_rem  = len_reg - rd_pos_reg;
    assign chunk_last = !pend_multi_reg || ((rd_pos_reg + 9'(pend_bytes_reg)) >= len_reg);

    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        wp_next         = wp_reg;
        seq_next        = seq_reg;
        recv_next       = recv_reg;
        data_next       = data_reg;
        wr_pos_next     = wr_pos_reg;
        src_next        = src_reg;
        left_next       = left_reg;
        after_push_next = after_push_reg;
        emit_next       = emit_reg;
        rd_pos_next     = rd_pos_reg;
        idx_next        = idx_reg;
        rd_pend_next    = 1'b0;
        slot_next       = slot_reg;
        pend_kind_next  = pend_kind_reg;
        pend_id_next    = pend_id_reg;
        pend_data_next  = pend_data_reg;
        pend_bytes_next = pend_bytes_reg;
        pend_mlen_next  = pend_mlen_reg;
        pend_multi_next = pend_multi_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_kind_next   = out_kind_reg;
        out_id_next     = out_id_reg;
        out_data_next   = out_data_reg;
        out_bytes_next  = out_bytes_reg;
        out_mlen_next   = out_mlen_reg;
        out_last_next   = out_last_reg;

        in_ready = (state_reg == ST_IDLE);
        wr_en    = 1'b0;
        wr_addr  = AW'(wr_pos_reg);
        wr_data  = data_reg[8*(7-src_reg) +: 8];
        rd_addr  = AW'(rd_pos_reg + 9'(idx_reg));

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    data_next = info.frame_data;
                    case (info.ftype)
                        isotp_rx_pkg::FT_SINGLE:
                        begin
                            pend_kind_next  = isotp_rx_pkg::KIND_CHUNK;
                            pend_id_next    = '0;
                            pend_data_next  = info.sf_word;
                            pend_bytes_next = info.sf_len;
                            pend_mlen_next  = 9'(info.sf_len);
                            pend_multi_next = 1'b0;
                            state_next      = ST_PUSH;
                        end
                        isotp_rx_pkg::FT_FIRST:
                        begin
                            // A first frame always restarts, even mid-reception.
                            len_next        = info.ff_len;
                            wp_next         = 9'(isotp_rx_pkg::FF_BYTES);
                            seq_next        = 4'd1;
                            recv_next       = 1'b1;
                            wr_pos_next     = '0;
                            src_next        = 3'd2;
                            left_next       = isotp_rx_pkg::FF_BYTES;
                            after_push_next = 1'b1;
                            emit_next       = 1'b0;
                            pend_kind_next  = isotp_rx_pkg::KIND_FLOW;
                            pend_id_next    = response_id;
                            pend_data_next  = {isotp_rx_pkg::FC_CTS_BYTE, 56'd0};
                            pend_bytes_next = 4'd8;
                            pend_mlen_next  = '0;
                            pend_multi_next = 1'b0;
                            state_next      = ST_WRITE;
                        end
                        isotp_rx_pkg::FT_CONSEC:
                        begin
                            if (recv_reg)
                            begin
                                if (info.nib != seq_reg)
                                begin
                                    recv_next = 1'b0;
                                end
                                else
                                begin
                                    wr_pos_next     = wp_reg;
                                    src_next        = 3'd1;
                                    left_next       = cf_n;
                                    wp_next         = cf_wp_end;
                                    seq_next        = seq_reg + 4'd1;
                                    after_push_next = 1'b0;
                                    emit_next       = (cf_wp_end >= len_reg) && (len_reg != 9'd0);
                                    if (cf_wp_end >= len_reg)
                                    begin
                                        recv_next = 1'b0;
                                    end
                                    state_next      = ST_WRITE;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_WRITE:
            begin
                if (left_reg != 3'd0)
                begin
                    wr_en       = (32'(wr_pos_reg) < BUFFER_BYTES);
                    wr_pos_next = wr_pos_reg + 9'd1;
                    src_next    = src_reg + 3'd1;
                    left_next   = left_reg - 3'd1;
                end
                else if (after_push_reg)
                begin
                    state_next = ST_PUSH;
                end
                else if (emit_reg)
                begin
                    rd_pos_next = '0;
                    state_next  = ST_CHUNK_START;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_CHUNK_START:
            begin
                pend_kind_next  = isotp_rx_pkg::KIND_CHUNK;
                pend_id_next    = '0;
                pend_data_next  = '0;
                pend_bytes_next = (chunk_rem > 9'd8) ? 4'd8 : chunk_rem[3:0];
                pend_mlen_next  = len_reg;
                pend_multi_next = 1'b1;
                idx_next        = '0;
                state_next      = ST_READ;
            end

            ST_READ:
            begin
                // Reads are pipelined: one address issued, one byte captured per cycle.
                if (rd_pend_reg)
                begin
                    pend_data_next[8*(7-slot_reg) +: 8] = rd_data;
                end
                if (idx_reg < pend_bytes_reg)
                begin
                    rd_pend_next = 1'b1;
                    slot_next    = idx_reg[2:0];
                    idx_next     = idx_reg + 4'd1;
                end
                else if (!rd_pend_reg)
                begin
                    state_next = ST_PUSH;
                end
            end

            ST_PUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = pend_kind_reg;
                    out_id_next    = pend_id_reg;
                    out_data_next  = pend_data_reg;
                    out_bytes_next = pend_bytes_reg;
                    out_mlen_next  = pend_mlen_reg;
                    out_last_next  = chunk_last;
                    if (pend_multi_reg)
                    begin
                        rd_pos_next = rd_pos_reg + 9'(pend_bytes_reg);
                    end
                    state_next = chunk_last ? ST_IDLE : ST_CHUNK_START;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            len_reg        <= '0;
            wp_reg         <= '0;
            seq_reg        <= '0;
            recv_reg       <= 1'b0;
            data_reg       <= '0;
            wr_pos_reg     <= '0;
            src_reg        <= '0;
            left_reg       <= '0;
            after_push_reg <= 1'b0;
            emit_reg       <= 1'b0;
            rd_pos_reg     <= '0;
            idx_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            slot_reg       <= '0;
            pend_kind_reg  <= 1'b0;
            pend_id_reg    <= '0;
            pend_data_reg  <= '0;
            pend_bytes_reg <= '0;
            pend_mlen_reg  <= '0;
            pend_multi_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= 1'b0;
            out_id_reg     <= '0;
            out_data_reg   <= '0;
            out_bytes_reg  <= '0;
            out_mlen_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            wp_reg         <= wp_next;
            seq_reg        <= seq_next;
            recv_reg       <= recv_next;
            data_reg       <= data_next;
            wr_pos_reg     <= wr_pos_next;
            src_reg        <= src_next;
            left_reg       <= left_next;
            after_push_reg <= after_push_next;
            emit_reg       <= emit_next;
            rd_pos_reg     <= rd_pos_next;
            idx_reg        <= idx_next;
            rd_pend_reg    <= rd_pend_next;
            slot_reg       <= slot_next;
            pend_kind_reg  <= pend_kind_next;
            pend_id_reg    <= pend_id_next;
            pend_data_reg  <= pend_data_next;
            pend_bytes_reg <= pend_bytes_next;
            pend_mlen_reg  <= pend_mlen_next;
            pend_multi_reg <= pend_multi_next;
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
            out_id_reg     <= out_id_next;
            out_data_reg   <= out_data_next;
            out_bytes_reg  <= out_bytes_next;
            out_mlen_reg   <= out_mlen_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {out_mlen_reg, out_bytes_reg, out_data_reg, out_id_reg};

    // Chunk reads never go past the end of the received message.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) && (idx_reg < pend_bytes_reg)
        |-> (rd_pos_reg + 9'(idx_reg)) < len_reg)
        else $error("chunk read beyond message length");

    // A chunk handed to the output carries one to eight bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_kind_reg == isotp_rx_pkg::KIND_CHUNK)
        |-> (out_bytes_reg != 4'd0) && (out_bytes_reg <= 4'd8))
        else $error("chunk with bad byte count");

    // While receiving, the write pointer is short of the length or sits just past the first frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        recv_reg |-> (wp_reg < len_reg) || (wp_reg == 9'(isotp_rx_pkg::FF_BYTES)))
        else $error("write pointer inconsistent with reception");

    // A chunk is only pushed while unread message bytes remain.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH) && out_free && pend_multi_reg |-> rd_pos_reg < len_reg)
        else $error("chunk pushed past end of message");

endmodule

### rtl/core/isotp_receive_reassembler.sv
// Top level of the ISO-TP receive reassembler: configuration registers, frame
// decoder, reassembly sequencer and message RAM. Depends on isotp_rx_pkg.
//
//   Channel   Direction  Handshake              Words
//   s_axis    in         tvalid/tready          received CAN frame
//   m_axis    out        tvalid/tready, tlast   flow control frame or message chunk
//   cfg       in         cfg_valid/cfg_ready    register index and value
//
// An ignored frame is dropped as it is accepted; a single frame moves the sequencer
// to its push step, which loads the result once the output is free. A first frame
// writes its bytes through the one-byte-per-cycle write port of the message RAM, as
// does a consecutive frame; a completed message is then read back chunk by chunk
// through the RAM read port. Reset idles the sequencer and loads the register
// defaults; the RAM needs no clearing. A stalled output holds the sequencer in its
// push step and no new frame is taken meanwhile.

module isotp_receive_reassembler #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // tdata: can_id[10:0], frame_length[14:11], frame_data[78:15], zero[79]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [isotp_rx_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // tdata: frame_id[10:0], chunk_data[74:11], chunk_bytes[78:75],
    //        message_length[87:79]
    // tuser: kind[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [isotp_rx_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int AW = $clog2(BUFFER_BYTES);

    logic        enable_reg;
    logic [10:0] request_id_reg;
    logic [10:0] response_id_reg;

    isotp_rx_pkg::cfg_t        cfg;
    isotp_rx_pkg::frame_info_t info;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            request_id_reg  <= isotp_rx_pkg::REQUEST_ID_RESET;
            response_id_reg <= isotp_rx_pkg::RESPONSE_ID_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                isotp_rx_pkg::REG_ENABLE:      enable_reg      <= cfg_data[0];
                isotp_rx_pkg::REG_REQUEST_ID:  request_id_reg  <= cfg_data;
                isotp_rx_pkg::REG_RESPONSE_ID: response_id_reg <= cfg_data;
                default:                       enable_reg      <= enable_reg;
            endcase
        end
    end

    assign cfg.enable      = enable_reg;
    assign cfg.request_id  = request_id_reg;
    assign cfg.response_id = response_id_reg;

    isotp_rx_decode #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_decode (
        .can_id      (s_axis_tdata[10:0]),
        .frame_length(s_axis_tdata[14:11]),
        .frame_data  (s_axis_tdata[78:15]),
        .cfg         (cfg),
        .info        (info)
    );

    isotp_rx_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_BYTES)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    isotp_rx_reasm #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .info         (info),
        .response_id  (cfg.response_id),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

endmodule
